[src/fpae_pkg.sv]
package fpae_pkg;

    localparam int MAX_PIXELS_DEF = 1024;

    localparam int WIN_W   = 11;
    localparam int CNT_W   = 16;
    localparam int TRY_W   = 8;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;

    // one quotient bit per division cycle
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    localparam logic [IDX_W-1:0] REG_WINDOW_START     = 3'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_STOP      = 3'd1;
    localparam logic [IDX_W-1:0] REG_TARGET_PEAK      = 3'd2;
    localparam logic [IDX_W-1:0] REG_TARGET_TOLERANCE = 3'd3;
    localparam logic [IDX_W-1:0] REG_DARK_LEVEL       = 3'd4;
    localparam logic [IDX_W-1:0] REG_EXPOSURE_FLOOR   = 3'd5;
    localparam logic [IDX_W-1:0] REG_EXPOSURE_CEILING = 3'd6;
    localparam logic [IDX_W-1:0] REG_TRY_LIMIT        = 3'd7;

    localparam logic [WIN_W-1:0] RST_WINDOW_START     = 11'd1;
    localparam logic [WIN_W-1:0] RST_WINDOW_STOP      = 11'd1024;
    localparam logic [CNT_W-1:0] RST_TARGET_PEAK      = 16'd46420;
    localparam logic [CNT_W-1:0] RST_TARGET_TOLERANCE = 16'd3277;
    localparam logic [CNT_W-1:0] RST_DARK_LEVEL       = 16'd4500;
    localparam logic [CNT_W-1:0] RST_EXPOSURE_FLOOR   = 16'd5;
    localparam logic [CNT_W-1:0] RST_EXPOSURE_CEILING = 16'd65535;
    localparam logic [TRY_W-1:0] RST_TRY_LIMIT        = 8'd10;

    typedef enum logic [4:0] {
        S_RUN   = 5'b00001,
        S_EVAL  = 5'b00010,
        S_DINIT = 5'b00100,
        S_DIV   = 5'b01000,
        S_FIN   = 5'b10000
    } fpae_state_t;

    typedef struct packed {
        logic start;
        logic pixel;
        logic last;
        logic eval;
        logic div_init;
        logic div_step;
        logic finish;
    } fpae_cmd_t;

    typedef struct packed {
        logic finished;
        logic need_div;
    } fpae_status_t;

endpackage

[src/fpae_ctrl.sv]
module fpae_ctrl
    import fpae_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         mode,
    input  logic         frame_end,
    output logic         out_valid,
    input  logic         out_stall,
    input  fpae_status_t status,
    output fpae_cmd_t    cmd
);

    fpae_state_t          state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 in_fire;
    logic                 out_free;

    assign in_stall  = (state_reg != S_RUN);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_RUN:
            begin
                if (in_fire && mode == MODE_START)
                begin
                    cmd.start = 1'b1;
                end
                else if (in_fire && mode == MODE_PIXEL && !status.finished)
                begin
                    cmd.pixel = 1'b1;
                    cmd.last  = frame_end;
                    if (frame_end)
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.need_div ? S_DINIT : S_FIN;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    div_cnt_next = '0;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result shown without a finish step");

    a_div_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DIV) |-> (div_cnt_reg == '0))
        else $error("division counter not cleared outside division");

    a_last_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pixel && cmd.last) |=> (state_reg == S_EVAL))
        else $error("frame end did not start the exposure step");

    a_eval_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |=> (state_reg == S_DINIT || state_reg == S_FIN))
        else $error("bad state after evaluation");
`endif

endmodule

[src/fpae_datapath.sv]
module fpae_datapath
    import fpae_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fpae_cmd_t         cmd,
    output fpae_status_t      status,
    input  logic [CNT_W-1:0]  sample_value,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_index,
    input  logic [DATA_W-1:0] wr_data,
    output logic [CNT_W-1:0]  exposure_out,
    output logic [CNT_W-1:0]  frame_peak,
    output logic [TRY_W-1:0]  tries_used,
    output logic              run_done,
    output logic              hit_target
);

    localparam int PW = $clog2(MAX_PIXELS + 2);
    localparam int CW = (PW > WIN_W) ? PW : WIN_W;

    // configuration
    logic [WIN_W-1:0] window_start_reg, window_stop_reg;
    logic [CNT_W-1:0] target_peak_reg, target_tolerance_reg, dark_level_reg;
    logic [CNT_W-1:0] exposure_floor_reg, exposure_ceiling_reg;
    logic [TRY_W-1:0] try_limit_reg;

    // run state
    logic [CNT_W-1:0] exposure_reg, exposure_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic [PW-1:0]    pixel_reg, pixel_next;
    logic [TRY_W-1:0] tries_reg, tries_next;
    logic             finished_reg, finished_next;
    logic             fin_pend_reg, fin_pend_next;
    logic             hit_reg, hit_next;
    logic             div_pend_reg, div_pend_next;

    // frame payload and divider
    logic [CNT_W-1:0]   peak_cap_reg;
    logic [2*CNT_W-1:0] prod_reg;
    logic [CNT_W-1:0]   rem_reg, quo_reg;
    logic               sat_reg;

    logic [PW-1:0]      pixel_inc;
    logic               in_window;
    logic [CNT_W-1:0]   peak_upd;
    logic [CNT_W:0]     band_sum;
    logic [CNT_W-1:0]   band_hi, band_lo, band_diff;
    logic               is_dark, is_above, is_below, at_ceil;
    logic [CNT_W+3:0]   times10;
    logic [CNT_W-1:0]   up10, halved;
    logic [CNT_W:0]     rem_shift, rem_sub;
    logic               quo_bit;
    logic [CNT_W-1:0]   div_result, exp_final;
    logic [TRY_W-1:0]   tries_inc;

    // pixel numbering and windowed peak
    always_comb
    begin
        pixel_inc = (pixel_reg <= PW'(MAX_PIXELS)) ? pixel_reg + 1'b1 : pixel_reg;
        in_window = (pixel_inc <= PW'(MAX_PIXELS))
                 && (CW'(pixel_inc) >= CW'(window_start_reg))
                 && (CW'(pixel_inc) <= CW'(window_stop_reg));
        peak_upd  = (in_window && sample_value > peak_reg) ? sample_value : peak_reg;
    end

    // band limits
    always_comb
    begin
        band_sum  = {1'b0, target_peak_reg} + {1'b0, target_tolerance_reg};
        band_hi   = band_sum[CNT_W] ? {CNT_W{1'b1}} : band_sum[CNT_W-1:0];
        band_diff = target_peak_reg - target_tolerance_reg;
        if (target_tolerance_reg > target_peak_reg || band_diff < dark_level_reg)
            band_lo = dark_level_reg;
        else
            band_lo = band_diff;
    end

    // step classification on the captured peak
    always_comb
    begin
        is_dark  = peak_cap_reg < dark_level_reg;
        is_above = peak_cap_reg > band_hi;
        is_below = peak_cap_reg < band_lo;
        at_ceil  = exposure_reg == exposure_ceiling_reg;
        times10  = {exposure_reg, 3'b000} + {2'b00, exposure_reg, 1'b0};
        up10     = (times10 > (CNT_W+4)'(exposure_ceiling_reg))
                 ? exposure_ceiling_reg : times10[CNT_W-1:0];
        halved   = ((exposure_reg >> 1) < exposure_floor_reg)
                 ? exposure_floor_reg : (exposure_reg >> 1);
    end

    assign status.finished = finished_reg;
    assign status.need_div = !is_dark && !is_above && is_below && !at_ceil
                          && (peak_cap_reg != '0);

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[CNT_W-1]};
        quo_bit   = rem_shift >= {1'b0, peak_cap_reg};
        rem_sub   = quo_bit ? rem_shift - {1'b0, peak_cap_reg} : rem_shift;
    end

    always_comb
    begin
        if (sat_reg || quo_reg > exposure_ceiling_reg)
            div_result = exposure_ceiling_reg;
        else
            div_result = quo_reg;
        exp_final = div_pend_reg ? div_result : exposure_reg;
        tries_inc = tries_reg + 1'b1;
    end

    always_comb
    begin
        exposure_next = exposure_reg;
        peak_next     = peak_reg;
        pixel_next    = pixel_reg;
        tries_next    = tries_reg;
        finished_next = finished_reg;
        fin_pend_next = fin_pend_reg;
        hit_next      = hit_reg;
        div_pend_next = div_pend_reg;
        if (cmd.start)
        begin
            exposure_next = sample_value;
            tries_next    = '0;
            finished_next = 1'b0;
            peak_next     = '0;
            pixel_next    = '0;
        end
        if (cmd.pixel)
        begin
            if (cmd.last)
            begin
                peak_next  = '0;
                pixel_next = '0;
            end
            else
            begin
                peak_next  = peak_upd;
                pixel_next = pixel_inc;
            end
        end
        if (cmd.eval)
        begin
            fin_pend_next = 1'b0;
            hit_next      = 1'b0;
            div_pend_next = status.need_div;
            if (is_dark)
            begin
                if (at_ceil)
                    fin_pend_next = 1'b1;
                else
                    exposure_next = up10;
            end
            else if (is_above)
            begin
                exposure_next = halved;
            end
            else if (is_below)
            begin
                if (at_ceil)
                    fin_pend_next = 1'b1;
                else if (peak_cap_reg == '0)
                    exposure_next = exposure_ceiling_reg;
            end
            else
            begin
                fin_pend_next = 1'b1;
                hit_next      = 1'b1;
            end
        end
        if (cmd.finish)
        begin
            exposure_next = exp_final;
            tries_next    = tries_inc;
            finished_next = fin_pend_reg || (tries_inc == try_limit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg     <= RST_WINDOW_START;
            window_stop_reg      <= RST_WINDOW_STOP;
            target_peak_reg      <= RST_TARGET_PEAK;
            target_tolerance_reg <= RST_TARGET_TOLERANCE;
            dark_level_reg       <= RST_DARK_LEVEL;
            exposure_floor_reg   <= RST_EXPOSURE_FLOOR;
            exposure_ceiling_reg <= RST_EXPOSURE_CEILING;
            try_limit_reg        <= RST_TRY_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_WINDOW_START:     window_start_reg     <= wr_data[WIN_W-1:0];
                REG_WINDOW_STOP:      window_stop_reg      <= wr_data[WIN_W-1:0];
                REG_TARGET_PEAK:      target_peak_reg      <= wr_data[CNT_W-1:0];
                REG_TARGET_TOLERANCE: target_tolerance_reg <= wr_data[CNT_W-1:0];
                REG_DARK_LEVEL:       dark_level_reg       <= wr_data[CNT_W-1:0];
                REG_EXPOSURE_FLOOR:   exposure_floor_reg   <= wr_data[CNT_W-1:0];
                REG_EXPOSURE_CEILING: exposure_ceiling_reg <= wr_data[CNT_W-1:0];
                REG_TRY_LIMIT:        try_limit_reg        <= wr_data[TRY_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exposure_reg <= '0;
            peak_reg     <= '0;
            pixel_reg    <= '0;
            tries_reg    <= '0;
            finished_reg <= 1'b1;
            fin_pend_reg <= 1'b0;
            hit_reg      <= 1'b0;
            div_pend_reg <= 1'b0;
        end
        else
        begin
            exposure_reg <= exposure_next;
            peak_reg     <= peak_next;
            pixel_reg    <= pixel_next;
            tries_reg    <= tries_next;
            finished_reg <= finished_next;
            fin_pend_reg <= fin_pend_next;
            hit_reg      <= hit_next;
            div_pend_reg <= div_pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.pixel && cmd.last)
        begin
            peak_cap_reg <= peak_upd;
        end
        if (cmd.eval)
        begin
            prod_reg <= target_peak_reg * exposure_reg;
        end
        if (cmd.div_init)
        begin
            // quotient overflows 16 bits when the high half already reaches the divisor
            rem_reg <= prod_reg[2*CNT_W-1:CNT_W];
            quo_reg <= prod_reg[CNT_W-1:0];
            sat_reg <= prod_reg[2*CNT_W-1:CNT_W] >= peak_cap_reg;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_sub[CNT_W-1:0];
            quo_reg <= {quo_reg[CNT_W-2:0], quo_bit};
        end
        if (cmd.finish)
        begin
            exposure_out <= exp_final;
            frame_peak   <= peak_cap_reg;
            tries_used   <= tries_inc;
            run_done     <= fin_pend_reg || (tries_inc == try_limit_reg);
            hit_target   <= hit_reg;
        end
    end

endmodule

[src/frame_peak_auto_exposure.sv]
// Auto-exposure regulator for a line sensor. A start item (mode 0) loads the
// initial exposure from sample_value and opens a run; pixel items (mode 1)
// are taken one per cycle and the peak inside the window is tracked. The
// item carrying frame_end closes the frame: input is then stalled through
// evaluate and finish, plus divider set-up and the bit-per-cycle divider
// when the peak sits below the band and the exposure is scaled by target/peak
// (16x16 product registered at evaluate). Finishing also waits for the previous
// result to be taken off the output register. One result per closed frame;
// pixels are ignored while no run is open. Configuration is written through
// wr_en/wr_index/wr_data by the user only while idle; the block does not check.
module frame_peak_auto_exposure
    import fpae_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              mode,
    input  logic [CNT_W-1:0]  sample_value,
    input  logic              frame_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CNT_W-1:0]  exposure_out,
    output logic [CNT_W-1:0]  frame_peak,
    output logic [TRY_W-1:0]  tries_used,
    output logic              run_done,
    output logic              hit_target,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_index,
    input  logic [DATA_W-1:0] wr_data
);

    fpae_cmd_t    cmd;
    fpae_status_t status;

    fpae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .frame_end (frame_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fpae_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_value (sample_value),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .exposure_out (exposure_out),
        .frame_peak   (frame_peak),
        .tries_used   (tries_used),
        .run_done     (run_done),
        .hit_target   (hit_target)
    );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import fpae_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int SETTLE      = 40;     // covers the divider path, plus margin
    localparam int LONG_HOLD   = 400;
    localparam int LONG_FRAME  = 1030;

    typedef struct packed {
        logic [CNT_W-1:0] exposure;
        logic [CNT_W-1:0] peak;
        logic [TRY_W-1:0] tries;
        logic             done;
        logic             hit;
    } expo_result_t;

    typedef struct packed {
        logic             md;
        logic [CNT_W-1:0] sample;
        logic             last;
        logic             typed;
        expo_result_t     want;
    } stim_row_t;

    typedef struct packed {
        logic [WIN_W-1:0] win_start;
        logic [WIN_W-1:0] win_stop;
        logic [CNT_W-1:0] target;
        logic [CNT_W-1:0] tol;
        logic [CNT_W-1:0] dark;
        logic [CNT_W-1:0] floor_lvl;
        logic [CNT_W-1:0] ceil_lvl;
        logic [TRY_W-1:0] tries;
    } expo_cfg_t;

    localparam expo_result_t NO_RESULT = '0;

    // reset config: band is 43143..49697, dark 4500, floor 5, ceiling 65535
    localparam stim_row_t DIRECTED [24] = '{
        '{MODE_PIXEL, 16'd1234,  1'b1, 1'b0, NO_RESULT},  // pixel before any start
        '{MODE_START, 16'd100,   1'b1, 1'b0, NO_RESULT},  // frame_end ignored on start
        '{MODE_PIXEL, 16'd0,     1'b0, 1'b0, NO_RESULT},
        '{MODE_PIXEL, 16'd65535, 1'b1, 1'b1, '{16'd50, 16'd65535, 8'd1, 1'b0, 1'b0}},
        '{MODE_PIXEL, 16'd0,     1'b1, 1'b1, '{16'd500, 16'd0, 8'd2, 1'b0, 1'b0}},
        '{MODE_PIXEL, 16'd46420, 1'b1, 1'b1, '{16'd500, 16'd46420, 8'd3, 1'b1, 1'b1}},
        '{MODE_PIXEL, 16'd5000,  1'b1, 1'b0, NO_RESULT},  // run already over
        '{MODE_START, 16'd65535, 1'b0, 1'b0, NO_RESULT},
        '{MODE_PIXEL, 16'd100,   1'b1, 1'b1, '{16'd65535, 16'd100, 8'd1, 1'b1, 1'b0}},
        '{MODE_START, 16'd7000,  1'b0, 1'b0, NO_RESULT},
        '{MODE_PIXEL, 16'd23210, 1'b1, 1'b1, '{16'd14000, 16'd23210, 8'd1, 1'b0, 1'b0}},
        '{MODE_PIXEL, 16'd49697, 1'b1, 1'b1, '{16'd14000, 16'd49697, 8'd2, 1'b1, 1'b1}},
        '{MODE_START, 16'd8,     1'b1, 1'b0, NO_RESULT},
        '{MODE_PIXEL, 16'd49698, 1'b1, 1'b1, '{16'd5, 16'd49698, 8'd1, 1'b0, 1'b0}},
        '{MODE_PIXEL, 16'd43142, 1'b1, 1'b1, '{16'd5, 16'd43142, 8'd2, 1'b0, 1'b0}},
        '{MODE_PIXEL, 16'd43143, 1'b1, 1'b1, '{16'd5, 16'd43143, 8'd3, 1'b1, 1'b1}},
        '{MODE_START, 16'd10000, 1'b0, 1'b0, NO_RESULT},
        '{MODE_PIXEL, 16'd4499,  1'b1, 1'b1, '{16'd65535, 16'd4499, 8'd1, 1'b0, 1'b0}},
        '{MODE_PIXEL, 16'd4500,  1'b1, 1'b1, '{16'd65535, 16'd4500, 8'd2, 1'b1, 1'b0}},
        '{MODE_START, 16'd1000,  1'b0, 1'b0, NO_RESULT},
        '{MODE_PIXEL, 16'd30000, 1'b0, 1'b0, NO_RESULT},
        '{MODE_PIXEL, 16'd20000, 1'b1, 1'b0, NO_RESULT},
        '{MODE_START, 16'd0,     1'b0, 1'b0, NO_RESULT},
        '{MODE_PIXEL, 16'd65535, 1'b1, 1'b0, NO_RESULT}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              mode = MODE_START;
    logic [CNT_W-1:0]  sample_value = '0;
    logic              frame_end = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CNT_W-1:0]  exposure_out;
    logic [CNT_W-1:0]  frame_peak;
    logic [TRY_W-1:0]  tries_used;
    logic              run_done;
    logic              hit_target;
    logic              wr_en = 1'b0;
    logic [IDX_W-1:0]  wr_index = REG_WINDOW_START;
    logic [DATA_W-1:0] wr_data = '0;

    // predictor copy of configuration and state
    logic [WIN_W-1:0]  cfg_win_start = RST_WINDOW_START;
    logic [WIN_W-1:0]  cfg_win_stop  = RST_WINDOW_STOP;
    logic [CNT_W-1:0]  cfg_target    = RST_TARGET_PEAK;
    logic [CNT_W-1:0]  cfg_tol       = RST_TARGET_TOLERANCE;
    logic [CNT_W-1:0]  cfg_dark      = RST_DARK_LEVEL;
    logic [CNT_W-1:0]  cfg_floor     = RST_EXPOSURE_FLOOR;
    logic [CNT_W-1:0]  cfg_ceil      = RST_EXPOSURE_CEILING;
    logic [TRY_W-1:0]  cfg_tries     = RST_TRY_LIMIT;

    logic [CNT_W-1:0]  cur_exposure = '0;
    logic [CNT_W-1:0]  cur_peak     = '0;
    logic [WIN_W-1:0]  cur_pixel    = '0;
    logic [TRY_W-1:0]  cur_tries    = '0;
    logic              run_over     = 1'b1;

    expo_result_t expected_frames[$];
    int  fails = 0;
    int  live_items = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  long_hold_req = 1'b0;

    frame_peak_auto_exposure uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .sample_value (sample_value),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .exposure_out (exposure_out),
        .frame_peak   (frame_peak),
        .tries_used   (tries_used),
        .run_done     (run_done),
        .hit_target   (hit_target),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [CNT_W-1:0] band_floor();
        logic [CNT_W-1:0] d;
        if (cfg_tol > cfg_target)
            return cfg_dark;
        d = cfg_target - cfg_tol;
        return (d < cfg_dark) ? cfg_dark : d;
    endfunction

    function automatic logic [CNT_W-1:0] band_top();
        logic [CNT_W:0] s;
        s = cfg_target + cfg_tol;
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
        case (idx)
            REG_WINDOW_START:     cfg_win_start = d[WIN_W-1:0];
            REG_WINDOW_STOP:      cfg_win_stop  = d[WIN_W-1:0];
            REG_TARGET_PEAK:      cfg_target    = d;
            REG_TARGET_TOLERANCE: cfg_tol       = d;
            REG_DARK_LEVEL:       cfg_dark      = d;
            REG_EXPOSURE_FLOOR:   cfg_floor     = d;
            REG_EXPOSURE_CEILING: cfg_ceil      = d;
            REG_TRY_LIMIT:        cfg_tries     = d[TRY_W-1:0];
            default: ;
        endcase
    endtask

    // one accepted item through the regulator; made=1 when a frame closes
    task automatic advance_exposure(input logic md, input logic [CNT_W-1:0] s,
                                    input logic last, output bit made,
                                    output expo_result_t r);
        logic [31:0]      wide;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] pk;
        bit               hit;
        made = 1'b0;
        r = NO_RESULT;
        if (md == MODE_START) begin
            cur_exposure = s;
            cur_tries = '0;
            run_over = 1'b0;
            cur_peak = '0;
            cur_pixel = '0;
            live_items++;
            return;
        end
        if (run_over)
            return;
        live_items++;
        if (cur_pixel <= MAX_PIXELS_DEF)
            cur_pixel++;
        if (cur_pixel <= MAX_PIXELS_DEF && cur_pixel >= cfg_win_start &&
            cur_pixel <= cfg_win_stop && s > cur_peak)
            cur_peak = s;
        if (!last)
            return;

        pk = cur_peak;
        lo = band_floor();
        hi = band_top();
        hit = 1'b0;
        if (pk < cfg_dark) begin
            if (cur_exposure == cfg_ceil)
                run_over = 1'b1;
            else begin
                wide = cur_exposure * 10;
                cur_exposure = (wide > cfg_ceil) ? cfg_ceil : wide[CNT_W-1:0];
            end
        end
        else if (pk > hi) begin
            cur_exposure = cur_exposure >> 1;
            if (cur_exposure < cfg_floor)
                cur_exposure = cfg_floor;
        end
        else if (pk < lo) begin
            if (cur_exposure == cfg_ceil)
                run_over = 1'b1;
            else if (pk == 0)
                cur_exposure = cfg_ceil;
            else begin
                wide = (cfg_target * cur_exposure) / pk;
                cur_exposure = (wide > cfg_ceil) ? cfg_ceil : wide[CNT_W-1:0];
            end
        end
        else begin
            run_over = 1'b1;
            hit = 1'b1;
        end
        cur_tries++;
        if (cur_tries == cfg_tries)
            run_over = 1'b1;
        cur_peak = '0;
        cur_pixel = '0;

        made = 1'b1;
        r = '{cur_exposure, pk, cur_tries, run_over, hit};
    endtask

    function automatic int pick_gap();
        int r;
        if (tx_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic push_item(input logic md, input logic [CNT_W-1:0] s, input logic last,
                             input logic typed, input expo_result_t typed_want);
        bit           made;
        expo_result_t r;
        int           gap;
        in_valid     <= 1'b1;
        mode         <= md;
        sample_value <= s;
        frame_end    <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        advance_exposure(md, s, last, made, r);
        if (made)
            expected_frames.push_back(typed ? typed_want : r);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= d;
        @(posedge clk);
        apply_reg(idx, d);
    endtask

    task automatic program_config(input expo_cfg_t c);
        write_reg(REG_WINDOW_START, DATA_W'(c.win_start));
        write_reg(REG_WINDOW_STOP, DATA_W'(c.win_stop));
        write_reg(REG_TARGET_PEAK, c.target);
        write_reg(REG_TARGET_TOLERANCE, c.tol);
        write_reg(REG_DARK_LEVEL, c.dark);
        write_reg(REG_EXPOSURE_FLOOR, c.floor_lvl);
        write_reg(REG_EXPOSURE_CEILING, c.ceil_lvl);
        write_reg(REG_TRY_LIMIT, DATA_W'(c.tries));
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // sender goes idle until every frame result is back, then lets the block settle
    task automatic drain_results();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_frames.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic expo_cfg_t random_config();
        expo_cfg_t c;
        c.win_start = WIN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1024)
                                                         : $urandom_range(1, 6));
        c.win_stop  = WIN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1024)
                                                         : $urandom_range(8, 1024));
        c.target    = CNT_W'($urandom_range(8000, 65535));
        c.tol       = CNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 8000));
        c.dark      = CNT_W'($urandom_range(1, c.target / 3));
        c.floor_lvl = CNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                                         : $urandom_range(1, 64));
        c.ceil_lvl  = CNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                                         : $urandom_range(20000, 65535));
        c.tries     = TRY_W'($urandom_range(1, 30));
        return c;
    endfunction

    function automatic logic [CNT_W-1:0] pick_start_exposure();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 16'd1;
            3:       return CNT_W'($urandom_range(1, 200));
            default: return CNT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // frame peak aimed at one of the step branches
    function automatic logic [CNT_W-1:0] pick_level(input bit bright);
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        lo = band_floor();
        hi = band_top();
        if (bright)
            return (hi < 16'hFFFF) ? CNT_W'($urandom_range(hi + 1, 65535)) : 16'hFFFF;
        case ($urandom_range(0, 7))
            0:       return (cfg_dark > 0) ? CNT_W'($urandom_range(0, cfg_dark - 1)) : '0;
            1, 2:    return (lo <= hi) ? CNT_W'($urandom_range(lo, hi))
                                       : CNT_W'($urandom_range(0, 65535));
            3:       return (hi < 16'hFFFF) ? CNT_W'($urandom_range(hi + 1, 65535))
                                            : 16'hFFFF;
            4:       return (lo > cfg_dark) ? CNT_W'($urandom_range(cfg_dark, lo - 1))
                                            : CNT_W'($urandom_range(0, 65535));
            5:       return '0;
            6:       return '1;
            default: return CNT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(41, 200);
    endfunction

    // runs of frames with random content; a little noise and some aborted frames
    task automatic play_runs(input int budget, input bit bright, input bit long_once,
                             input bit hold_mid);
        int               stop_at;
        int               len;
        int               pos;
        int               k;
        bit               broken;
        bit               long_now;
        bit               hold_sent;
        logic [CNT_W-1:0] cap;
        logic [CNT_W-1:0] v;
        stop_at = live_items + budget;
        hold_sent = 1'b0;
        while (live_items < stop_at) begin
            if ((live_items % 50) == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            if (hold_mid && !hold_sent && live_items >= stop_at - budget / 2) begin
                long_hold_req = 1'b1;
                hold_sent = 1'b1;
            end
            if (!bright && $urandom_range(0, 99) < 6) begin
                push_item(1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
                continue;
            end
            push_item(MODE_START, pick_start_exposure(), 1'($urandom_range(0, 1)), 1'b0,
                      NO_RESULT);
            while (!run_over && live_items < stop_at) begin
                long_now = long_once;
                long_once = 1'b0;
                len = long_now ? LONG_FRAME : (bright ? 1 : pick_frame_len());
                cap = pick_level(bright);
                pos = $urandom_range(1, len);
                broken = !bright && ($urandom_range(0, 99) < 4);
                for (k = 1; k <= len; k++) begin
                    if (long_now && k > MAX_PIXELS_DEF)
                        v = '1;     // beyond the sensor length, must not count
                    else if (k == pos)
                        v = cap;
                    else
                        v = CNT_W'($urandom_range(0, cap));
                    push_item(MODE_PIXEL, v, (k == len) && !broken, 1'b0, NO_RESULT);
                end
                if (broken)
                    break;
            end
            if (run_over && $urandom_range(0, 99) < 30) begin
                repeat ($urandom_range(1, 3))
                    push_item(MODE_PIXEL, CNT_W'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
            end
        end
    endtask

    // output side: random stalls, quiet stretches and one long hold on request
    initial
    begin : rx_side
        int hold_left;
        int cyc;
        int r;
        hold_left = 0;
        cyc = 0;
        forever begin
            @(posedge clk);
            cyc++;
            if ((cyc % 200) == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (rx_quiet)
                out_stall <= 1'b0;
            else begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    out_stall <= 1'b0;
                else begin
                    hold_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(7, 39);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : frame_check
        expo_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (expected_frames.size() == 0) begin
                $error("unexpected result: exposure_out=%0d frame_peak=%0d",
                       exposure_out, frame_peak);
                fails++;
            end
            else begin
                want = expected_frames.pop_front();
                compare_field("exposure_out", want.exposure, exposure_out);
                compare_field("frame_peak", want.peak, frame_peak);
                compare_field("tries_used", CNT_W'(want.tries), CNT_W'(tries_used));
                compare_field("run_done", CNT_W'(want.done), CNT_W'(run_done));
                compare_field("hit_target", CNT_W'(want.hit), CNT_W'(hit_target));
            end
        end
    end

    initial
    begin : stimulus
        expo_cfg_t c;
        int        i;
        int        p;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (i = 0; i < $size(DIRECTED); i++)
            push_item(DIRECTED[i].md, DIRECTED[i].sample, DIRECTED[i].last,
                      DIRECTED[i].typed, DIRECTED[i].want);

        play_runs(100, 1'b0, 1'b0, 1'b0);

        for (p = 1; p <= 8; p++) begin
            drain_results();
            case (p)
                // all lows, window start of zero, one try per run
                1: c = '{11'd0, 11'd1024, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 8'd1};
                // all highs, window on the last pixel only
                2: c = '{11'd1024, 11'd1024, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 8'd255};
                // empty window with no dark level: zero peak below the band
                3: c = '{11'd5, 11'd3, 16'd40000, 16'd1000, 16'd0, 16'd1, 16'd50000,
                         8'd20};
                // try limit of zero with every frame too bright: counter wraps
                4: c = '{11'd1, 11'd1024, 16'd1000, 16'd100, 16'd500, 16'd1, 16'hFFFF,
                         8'd0};
                default: c = random_config();
            endcase
            program_config(c);
            play_runs((p == 4) ? 320 : 40, p == 4, p == 2, p == 6);
        end

        drain_results();
        if (expected_frames.size() != 0) begin
            $error("%0d expected results never arrived", expected_frames.size());
            fails++;
        end
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
